// ----- rtl/unique_mode_finder_defines.svh -----
// Assertion macros shared by the unique mode finder RTL.
`ifndef UNIQUE_MODE_FINDER_DEFINES_SVH
`define UNIQUE_MODE_FINDER_DEFINES_SVH

// Same-cycle implication, checked on clk and disabled during rst.
`define UMF_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("unique_mode_finder assertion failed");

// Next-cycle implication, checked on clk and disabled during rst.
`define UMF_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("unique_mode_finder assertion failed");

`endif

// ----- rtl/umf_pkg.sv -----
// Types and constants of the unique mode finder.
`default_nettype none

package umf_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int TABLE_DEPTH_DEF = 64;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_MULTI    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    value_t sample;
    logic   is_last;
    logic   no_value;
  } item_t;

  typedef struct packed {
    value_t  mode_value;
    count_t  top_count;
    status_t status;
  } result_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    logic   pending;
    logic   ovf;
    logic   multi;
    value_t sample;
    count_t best;
    value_t mode;
  } tok_t;

endpackage

`default_nettype wire

// ----- rtl/unique_mode_finder.sv -----
// Top level of the unique mode finder: a chain of table cells and the result register.
//
//   channel  direction  handshake                  payload
//   item     into       item_valid / item_stall    item   (sample, is_last, no_value)
//   result   out of     result_valid / result_stall result (mode_value, top_count, status)
//
// One transaction enters per cycle while item_stall is low; it walks the TABLE_DEPTH cells one
// cell a cycle while the chain advances, and its set's result is registered at the chain's end.
// Reset is synchronous and clears all cells at once; no clearing pass follows.
// The chain freezes only while a finished set sits at its end and the result register is stalled.
`default_nettype none

module unique_mode_finder #(
  parameter int TABLE_DEPTH = umf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_stall,
  input  wire umf_pkg::item_t item,
  output logic              result_valid,
  input  wire logic         result_stall,
  output umf_pkg::result_t  result
);

  umf_pkg::tok_t    chain [TABLE_DEPTH+1];
  umf_pkg::tok_t    tail;
  umf_pkg::result_t fin;
  logic             advance;
  logic             ovf_seen;
  logic             ovf_all;

  always_comb begin
    chain[0].valid   = item_valid;
    chain[0].last    = item.is_last;
    chain[0].pending = !item.no_value;
    chain[0].ovf     = 1'b0;
    chain[0].multi   = 1'b0;
    chain[0].sample  = item.sample;
    chain[0].best    = '0;
    chain[0].mode    = '0;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    umf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign tail       = chain[TABLE_DEPTH];
  assign advance    = !(tail.valid && tail.last && result_valid && result_stall);
  assign item_stall = !advance;
  assign ovf_all    = ovf_seen || tail.ovf || tail.pending;

  always_comb begin
    if (ovf_all) begin
      fin.status     = umf_pkg::ST_OVERFLOW;
      fin.mode_value = '0;
      fin.top_count  = '0;
    end else if (tail.best == '0) begin
      fin.status     = umf_pkg::ST_EMPTY;
      fin.mode_value = '0;
      fin.top_count  = '0;
    end else if (tail.multi) begin
      fin.status     = umf_pkg::ST_MULTI;
      fin.mode_value = '0;
      fin.top_count  = tail.best;
    end else begin
      fin.status     = umf_pkg::ST_OK;
      fin.mode_value = tail.mode;
      fin.top_count  = tail.best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      ovf_seen     <= 1'b0;
    end else begin
      if (advance && tail.valid && tail.last) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      if (advance && tail.valid) begin
        if (tail.last) begin
          ovf_seen <= 1'b0;
        end else if (tail.ovf || tail.pending) begin
          ovf_seen <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tail.valid && tail.last) begin
      result <= fin;
    end
  end

`include "unique_mode_finder_defines.svh"

  `UMF_ASSERT_IMP(a_stall_only_on_held_set, item_stall, result_valid && result_stall && tail.valid && tail.last)
  `UMF_ASSERT_NXT(a_chain_frozen, item_stall, $stable(tail))
  `UMF_ASSERT_IMP(a_error_mode_zero, result_valid && (result.status != umf_pkg::ST_OK), result.mode_value == '0)
  `UMF_ASSERT_IMP(a_no_count_on_empty, result_valid && (result.status == umf_pkg::ST_EMPTY || result.status == umf_pkg::ST_OVERFLOW), result.top_count == '0)
  `UMF_ASSERT_NXT(a_sticky_cleared, advance && tail.valid && tail.last, !ovf_seen && result_valid)

endmodule

`default_nettype wire

// ----- rtl/umf_cell.sv -----
// One table cell: holds a value and its count and passes the token on.
`default_nettype none

module umf_cell (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         advance,
  input  wire umf_pkg::tok_t tok_in,
  output umf_pkg::tok_t     tok_out
);

  logic            used;
  logic            used_next;
  umf_pkg::value_t value;
  umf_pkg::value_t value_next;
  umf_pkg::count_t count;
  umf_pkg::count_t count_next;
  umf_pkg::tok_t   tok_next;
  logic            hit;
  logic            place;
  logic            sat;
  logic            used_upd;

  always_comb begin
    hit        = tok_in.valid && tok_in.pending && used && (value == tok_in.sample);
    place      = tok_in.valid && tok_in.pending && !used;
    sat        = hit && (count == umf_pkg::COUNT_MAX);
    value_next = place ? tok_in.sample : value;
    if (place) begin
      count_next = umf_pkg::count_t'(1);
    end else if (hit && !sat) begin
      count_next = count + umf_pkg::count_t'(1);
    end else begin
      count_next = count;
    end
    used_upd         = used || place;
    tok_next         = tok_in;
    tok_next.pending = tok_in.pending && !hit && !place;
    tok_next.ovf     = tok_in.ovf || sat;
    if (tok_in.valid && tok_in.last && used_upd) begin
      if (count_next > tok_in.best) begin
        tok_next.best  = count_next;
        tok_next.mode  = value_next;
        tok_next.multi = 1'b0;
      end else if (count_next == tok_in.best) begin
        tok_next.multi = 1'b1;
      end
    end
    used_next = (tok_in.valid && tok_in.last) ? 1'b0 : used_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= 1'b0;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      used    <= used_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      value <= value_next;
      count <= count_next;
    end
  end

endmodule

`default_nettype wire
